@@ hw/rtl/pdau_pkg.sv @@
// Shared types and constants of the PID deadband anti-windup unit.
package pdau_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_UPPER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LOWER   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE   = 3'd6;

    localparam logic [1:0] MUL_ERR_DT = 2'd0;
    localparam logic [1:0] MUL_P      = 2'd1;
    localparam logic [1:0] MUL_I      = 2'd2;
    localparam logic [1:0] MUL_D      = 2'd3;

    typedef struct packed {
        logic       load;
        logic       calc_err;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       integ_upd;
        logic       div_start;
        logic       div_step;
        logic       acc_first;
        logic       acc_add;
        logic       finish;
    } t_dp_cmd;

    typedef struct packed {
        logic special;
        logic div_last;
        logic out_free;
    } t_dp_stat;

endpackage

@@ hw/rtl/pid_deadband_antiwindup_unit.sv @@
// Top level of the PID deadband anti-windup unit.
// One control step in signed fixed point per input transfer, one result transfer each.
// A compute step runs from acceptance to the result register through the restoring
// divider for the derivative, which yields one quotient bit per cycle, and four passes
// through the one shared multiplier. A clear or a zero time step skips both. One step
// runs at a time; the next input is taken while the previous result waits in the
// output register. Configuration writes take effect at once and are to be made while
// idle; the block itself does not enforce this.
module pid_deadband_antiwindup_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pdau_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_WIDTH-1:0]          i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_cmd,
    input  logic signed [DATA_WIDTH-1:0]   i_setpoint,
    input  logic signed [DATA_WIDTH-1:0]   i_measured,
    input  logic [DATA_WIDTH-1:0]          i_step_time,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [DATA_WIDTH-1:0]   o_drive
);
    import pdau_pkg::*;

    t_dp_cmd  ctl;
    t_dp_stat stat;

    pdau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (ctl)
    );

    pdau_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (i_cmd),
        .i_setpoint  (i_setpoint),
        .i_measured  (i_measured),
        .i_step_time (i_step_time),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_drive     (o_drive),
        .i_ctl       (ctl),
        .o_stat      (stat)
    );

endmodule

@@ hw/rtl/pdau_ctrl.sv @@
// Sequencing state machine of the PID deadband anti-windup unit.
module pdau_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pdau_pkg::t_dp_stat i_stat,
    output pdau_pkg::t_dp_cmd  o_cmd
);
    import pdau_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ERR  = 4'd1;
    localparam logic [3:0] S_MI   = 4'd2;
    localparam logic [3:0] S_INT  = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_MP   = 4'd5;
    localparam logic [3:0] S_MIG  = 4'd6;
    localparam logic [3:0] S_MD   = 4'd7;
    localparam logic [3:0] S_SUM  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ERR;
                end
            end
            S_ERR: begin
                o_cmd.calc_err = 1'b1;
                n_state = i_stat.special ? S_FIN : S_MI;
            end
            S_MI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_ERR_DT;
                n_state = S_INT;
            end
            S_INT: begin
                o_cmd.integ_upd = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_MP;
                end
            end
            S_MP: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_P;
                n_state = S_MIG;
            end
            S_MIG: begin
                o_cmd.acc_first = 1'b1;
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_sel   = MUL_I;
                n_state = S_MD;
            end
            S_MD: begin
                o_cmd.acc_add = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_D;
                n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.acc_add = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_ERR))
        else $error("accepted transfer did not start a step");
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_stat.div_last) |=> (r_state == S_MP))
        else $error("divider did not hand over to the gain products");
    a_fin_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (r_state == S_FIN && i_stat.out_free))
        else $error("result written without a free output register");
`endif

endmodule

@@ hw/rtl/pdau_dp.sv @@
// Datapath of the PID deadband anti-windup unit: registers, multiplier, divider.
module pdau_dp #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pdau_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [DATA_WIDTH-1:0]              i_cfg_data,
    input  logic                               i_cmd,
    input  logic signed [DATA_WIDTH-1:0]       i_setpoint,
    input  logic signed [DATA_WIDTH-1:0]       i_measured,
    input  logic [DATA_WIDTH-1:0]              i_step_time,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [DATA_WIDTH-1:0]       o_drive,
    input  pdau_pkg::t_dp_cmd                  i_ctl,
    output pdau_pkg::t_dp_stat                 o_stat
);
    import pdau_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int MW = DW + 1;
    localparam int PW = 2 * MW;
    localparam int AW = DW + 2;
    localparam int QW = DW + 1 + FRAC_BITS;
    localparam int CW = $clog2(QW);
    localparam logic [CW-1:0] CNT_LAST = CW'(QW - 1);

    logic signed [DW-1:0] r_gain_p, r_gain_i, r_gain_d, r_out_upper, r_out_lower;
    logic [DW-2:0]        r_integ_limit, r_dead_zone;

    logic                 r_clr;
    logic signed [DW-1:0] r_sp, r_meas;
    logic [DW-1:0]        r_dt;

    logic signed [DW-1:0] r_err, r_prev_err, r_integ, r_prev_drive, r_deriv;
    logic signed [PW-1:0] r_prod;
    logic signed [AW-1:0] r_acc;
    logic [DW-1:0]        r_rem;
    logic [QW-1:0]        r_quo;
    logic                 r_dneg;
    logic [CW-1:0]        r_cnt;
    logic                 r_out_valid;
    logic signed [DW-1:0] r_drive;

    function automatic logic signed [DW-1:0] sat_pw(input logic signed [PW-1:0] v);
        logic signed [DW-1:0] res;
        if (&v[PW-1:DW-1] || ~|v[PW-1:DW-1]) begin
            res = v[DW-1:0];
        end else begin
            res = v[PW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end
        return res;
    endfunction

    function automatic logic signed [DW-1:0] sat_aw(input logic signed [AW-1:0] v);
        logic signed [DW-1:0] res;
        if (&v[AW-1:DW-1] || ~|v[AW-1:DW-1]) begin
            res = v[DW-1:0];
        end else begin
            res = v[AW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end
        return res;
    endfunction

    // Error with saturation and dead zone.
    logic signed [DW:0]   err_diff;
    logic signed [AW-1:0] err_wide;
    logic signed [DW-1:0] err_sat;
    logic [DW-1:0]        err_mag;
    logic signed [DW-1:0] err_dz;

    assign err_diff = DW'(0) + ({r_sp[DW-1], r_sp} - {r_meas[DW-1], r_meas});
    assign err_wide = {err_diff[DW], err_diff};
    assign err_sat  = sat_aw(err_wide);
    assign err_mag  = err_sat[DW-1] ? DW'(-err_sat) : DW'(err_sat);
    assign err_dz   = (err_mag < {1'b0, r_dead_zone}) ? '0 : err_sat;

    // Shared multiplier operands and scaled product.
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod_sh;
    logic signed [DW-1:0] term;

    always_comb begin
        unique case (i_ctl.mul_sel)
            MUL_ERR_DT: begin
                mul_a = {r_err[DW-1], r_err};
                mul_b = {1'b0, r_dt};
            end
            MUL_P: begin
                mul_a = {r_gain_p[DW-1], r_gain_p};
                mul_b = {r_err[DW-1], r_err};
            end
            MUL_I: begin
                mul_a = {r_gain_i[DW-1], r_gain_i};
                mul_b = {r_integ[DW-1], r_integ};
            end
            default: begin
                mul_a = {r_gain_d[DW-1], r_gain_d};
                mul_b = {r_deriv[DW-1], r_deriv};
            end
        endcase
    end

    assign prod_sh = r_prod >>> FRAC_BITS;
    assign term    = sat_pw(prod_sh);

    // Integral update with clamp.
    logic signed [DW:0] integ_sum, integ_lim;
    logic signed [DW-1:0] integ_next;

    assign integ_sum = {r_integ[DW-1], r_integ} + {term[DW-1], term};
    assign integ_lim = {2'b00, r_integ_limit};

    always_comb begin
        if (integ_sum > integ_lim) begin
            integ_next = integ_lim[DW-1:0];
        end else if (integ_sum < -integ_lim) begin
            integ_next = DW'(-integ_lim);
        end else begin
            integ_next = integ_sum[DW-1:0];
        end
    end

    // Derivative divider: restoring, one quotient bit per cycle.
    logic signed [DW:0] d_diff;
    logic [DW:0]        d_mag;
    logic [DW:0]        div_trial;
    logic               div_ge;
    logic [QW-1:0]      d_lim;
    logic [DW-1:0]      d_val;

    assign d_diff    = {r_err[DW-1], r_err} - {r_prev_err[DW-1], r_prev_err};
    assign d_mag     = d_diff[DW] ? (DW + 1)'(-d_diff) : (DW + 1)'(d_diff);
    assign div_trial = {r_rem, r_quo[QW-1]};
    assign div_ge    = (div_trial >= {1'b0, r_dt});
    assign d_lim     = r_dneg ? (QW'(1) << (DW - 1)) : ((QW'(1) << (DW - 1)) - QW'(1));
    assign d_val     = (r_quo > d_lim) ? d_lim[DW-1:0] : r_quo[DW-1:0];

    // Drive sum, saturation and output limits.
    logic signed [DW-1:0] drv_sat, drv_hi, drv_clamp, fin_drive;

    assign drv_sat   = sat_aw(r_acc);
    assign drv_hi    = (drv_sat > r_out_upper) ? r_out_upper : drv_sat;
    assign drv_clamp = (drv_hi < r_out_lower) ? r_out_lower : drv_hi;
    assign fin_drive = r_clr ? '0 : ((r_dt == '0) ? r_prev_drive : drv_clamp);

    assign o_stat.special  = r_clr || (r_dt == '0);
    assign o_stat.div_last = (r_cnt == CNT_LAST);
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_drive         = r_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p      <= '0;
            r_gain_i      <= '0;
            r_gain_d      <= '0;
            r_out_upper   <= {1'b0, {(DW-1){1'b1}}};
            r_out_lower   <= {1'b1, {(DW-1){1'b0}}};
            r_integ_limit <= '1;
            r_dead_zone   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAIN_P:      r_gain_p      <= i_cfg_data;
                CFG_GAIN_I:      r_gain_i      <= i_cfg_data;
                CFG_GAIN_D:      r_gain_d      <= i_cfg_data;
                CFG_OUT_UPPER:   r_out_upper   <= i_cfg_data;
                CFG_OUT_LOWER:   r_out_lower   <= i_cfg_data;
                CFG_INTEG_LIMIT: r_integ_limit <= i_cfg_data[DW-2:0];
                CFG_DEAD_ZONE:   r_dead_zone   <= i_cfg_data[DW-2:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_clr  <= i_cmd;
            r_sp   <= i_setpoint;
            r_meas <= i_measured;
            r_dt   <= i_step_time;
        end
        if (i_ctl.calc_err) begin
            r_err <= err_dz;
        end
        if (i_ctl.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_ctl.mul_en && i_ctl.mul_sel == MUL_P) begin
            r_deriv <= r_dneg ? DW'(-d_val) : d_val;
        end
        if (i_ctl.div_start) begin
            r_rem  <= '0;
            r_quo  <= {d_mag, {FRAC_BITS{1'b0}}};
            r_dneg <= d_diff[DW];
            r_cnt  <= '0;
        end else if (i_ctl.div_step) begin
            r_rem  <= div_ge ? DW'(div_trial - {1'b0, r_dt}) : div_trial[DW-1:0];
            r_quo  <= {r_quo[QW-2:0], div_ge};
            r_cnt  <= r_cnt + CW'(1);
        end
        if (i_ctl.acc_first) begin
            r_acc <= AW'(term);
        end else if (i_ctl.acc_add) begin
            r_acc <= r_acc + AW'(term);
        end
        if (i_ctl.finish) begin
            r_drive <= fin_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ      <= '0;
            r_prev_err   <= '0;
            r_prev_drive <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_ctl.integ_upd) begin
                r_integ <= integ_next;
            end
            if (i_ctl.finish) begin
                if (r_clr) begin
                    r_integ      <= '0;
                    r_prev_err   <= '0;
                    r_prev_drive <= '0;
                end else if (r_dt != '0) begin
                    r_prev_err   <= r_err;
                    r_prev_drive <= drv_clamp;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_ctl.finish))
        else $error("result appeared without a finished step");
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.finish && r_clr) |=> (r_integ == '0 && r_prev_drive == '0 && r_drive == '0))
        else $error("clear did not zero the controller state");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_drive)))
        else $error("waiting result changed before its transfer");
`endif

endmodule
